@@ design/ple_pkg.sv @@
// Shared constants, codes and types of the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int FUNC_W   = 3;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 40;

  localparam logic [FUNC_W-1:0] FN_LIST      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_END   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_END   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  // One cycle of slot store traffic: one read and one write port.
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] ra;
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [VAL_W-1:0] wd;
  } ple_mem_req_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_LIST  = 4'b0100,
    ST_EMIT  = 4'b1000
  } ple_state_t;

endpackage

`default_nettype wire

@@ design/positional_list_engine_core.sv @@
// Top level of the positional list engine: request decode, shift and list sequencer.
`default_nettype none

// Channel  Direction  Payload (lowest bit up)                          Handshake
// in_      slave      tdata: func[2:0] position[8:3] new_value[40:9]   in_tvalid/in_tready
// out_     master     tdata: status[1:0] item_value[33:2]; tlast=last  out_tvalid/out_tready
//
// Sequencing: one request at a time; an insert or delete at element idx of n entries shifts
// its entries in ST_SHIFT, one entry moved per cycle, then loads its item in ST_EMIT;
// a list streams one item per cycle while out_tready is high.
// Reset: rst_n clears the entry count; the slot store holds no reset value.
// Stalls: out_tready low holds the output register and pauses the list stream;
// in_tready is high only while the sequencer is idle.

module positional_list_engine_core (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [ple_pkg::IN_W-1:0] in_tdata,   // func, position, new_value
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [ple_pkg::OUT_W-1:0]     out_tdata,  // status, item_value
  output logic                          out_tlast
);

  localparam int IDX_W = ple_pkg::IDX_W;
  localparam int CNT_W = ple_pkg::CNT_W;
  localparam int CMP_W = ple_pkg::CMP_W;
  localparam int VAL_W = ple_pkg::VAL_W;

  ple_pkg::ple_state_t      state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         left_r, left_nxt;     // reads still to issue
  logic [IDX_W-1:0]         ptr_r, ptr_nxt;       // next read address
  logic                     rdv_r, rdv_nxt;       // read data valid
  logic [IDX_W-1:0]         rd_addr_r, rd_addr_nxt;
  logic                     rd_last_r, rd_last_nxt;
  logic                     ins_r, ins_nxt;       // shift up (insert) or down (delete)
  logic                     first_r, first_nxt;   // first delete read is the removed value
  logic [IDX_W-1:0]         ins_idx_r, ins_idx_nxt;
  logic [VAL_W-1:0]         ins_val_r, ins_val_nxt;
  logic [1:0]               res_status_r, res_status_nxt;
  logic [VAL_W-1:0]         res_value_r, res_value_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  logic [VAL_W-1:0]         out_value_r, out_value_nxt;
  logic                     out_last_r, out_last_nxt;

  ple_pkg::ple_mem_req_t    mem_req;
  logic [VAL_W-1:0]         rd_data;

  logic                     in_fire;
  logic                     out_free;
  logic                     load_out;
  logic                     issue;
  logic [ple_pkg::FUNC_W-1:0] func;
  logic [ple_pkg::POS_W-1:0]  pos;
  logic [VAL_W-1:0]         new_val;
  logic [CMP_W-1:0]         pos_x, cnt_x;
  logic [CNT_W-1:0]         idx_c;
  logic                     full_c;

  ple_slot_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign func    = in_tdata[2:0];
  assign pos     = in_tdata[8:3];
  assign new_val = in_tdata[40:9];
  assign pos_x   = CMP_W'(pos);
  assign cnt_x   = CMP_W'(count_r);
  assign full_c  = (count_r >= CNT_W'(ple_pkg::CAPACITY));

  assign in_tready = (state_r == ple_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Element index that the request works on.
  always_comb begin
    case (func)
      ple_pkg::FN_INS_END: idx_c = count_r;
      ple_pkg::FN_DEL_END: idx_c = count_r - CNT_W'(1);
      ple_pkg::FN_INS_AT,
      ple_pkg::FN_DEL_AT:  idx_c = CNT_W'(pos_x - CMP_W'(1));
      default:             idx_c = '0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    ptr_nxt        = ptr_r;
    rdv_nxt        = rdv_r;
    rd_addr_nxt    = rd_addr_r;
    rd_last_nxt    = rd_last_r;
    ins_nxt        = ins_r;
    first_nxt      = first_r;
    ins_idx_nxt    = ins_idx_r;
    ins_val_nxt    = ins_val_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    mem_req        = '0;
    load_out       = 1'b0;
    issue          = 1'b0;

    case (state_r)
      ple_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_status_nxt = ple_pkg::STAT_OK;
          res_value_nxt  = '0;
          state_nxt      = ple_pkg::ST_EMIT;
          case (func)
            ple_pkg::FN_LIST: begin
              if (count_r == '0) begin
                res_status_nxt = ple_pkg::STAT_EMPTY;
              end else begin
                ptr_nxt   = '0;
                left_nxt  = count_r;
                rdv_nxt   = 1'b0;
                state_nxt = ple_pkg::ST_LIST;
              end
            end
            ple_pkg::FN_INS_FRONT,
            ple_pkg::FN_INS_END,
            ple_pkg::FN_INS_AT: begin
              if (full_c) begin
                res_status_nxt = ple_pkg::STAT_FULL;
              end else if ((func == ple_pkg::FN_INS_AT) &&
                           ((pos == '0) || (pos_x > cnt_x + CMP_W'(1)))) begin
                res_status_nxt = ple_pkg::STAT_BADPOS;
              end else begin
                // Shift entries idx..n-1 up by one, top first.
                ins_nxt     = 1'b1;
                ins_idx_nxt = IDX_W'(idx_c);
                ins_val_nxt = new_val;
                ptr_nxt     = IDX_W'(count_r - CNT_W'(1));
                left_nxt    = count_r - idx_c;
                rdv_nxt     = 1'b0;
                state_nxt   = ple_pkg::ST_SHIFT;
              end
            end
            ple_pkg::FN_DEL_FRONT,
            ple_pkg::FN_DEL_END,
            ple_pkg::FN_DEL_AT: begin
              if (count_r == '0) begin
                res_status_nxt = ple_pkg::STAT_EMPTY;
              end else if ((func == ple_pkg::FN_DEL_AT) &&
                           ((pos == '0) || (pos_x > cnt_x))) begin
                res_status_nxt = ple_pkg::STAT_BADPOS;
              end else begin
                // Read the removed entry, then move idx+1..n-1 down by one.
                ins_nxt   = 1'b0;
                first_nxt = 1'b1;
                ptr_nxt   = IDX_W'(idx_c);
                left_nxt  = count_r - idx_c;
                rdv_nxt   = 1'b0;
                state_nxt = ple_pkg::ST_SHIFT;
              end
            end
            default: begin
              res_status_nxt = ple_pkg::STAT_OK;
            end
          endcase
        end
      end

      ple_pkg::ST_SHIFT: begin
        issue = (left_r != '0);
        if (issue) begin
          mem_req.re = 1'b1;
          mem_req.ra = ptr_r;
          ptr_nxt    = ins_r ? (ptr_r - IDX_W'(1)) : (ptr_r + IDX_W'(1));
          left_nxt   = left_r - CNT_W'(1);
        end
        rdv_nxt     = issue;
        rd_addr_nxt = ptr_r;
        if (rdv_r) begin
          if (ins_r) begin
            mem_req.we = 1'b1;
            mem_req.wa = rd_addr_r + IDX_W'(1);
            mem_req.wd = rd_data;
          end else if (first_r) begin
            res_value_nxt = rd_data;
            first_nxt     = 1'b0;
          end else begin
            mem_req.we = 1'b1;
            mem_req.wa = rd_addr_r - IDX_W'(1);
            mem_req.wd = rd_data;
          end
        end
        if (!issue && !rdv_r) begin
          // Shifting done: for an insert, drop the new value into its slot; settle the count.
          if (ins_r) begin
            mem_req.we = 1'b1;
            mem_req.wa = ins_idx_r;
            mem_req.wd = ins_val_r;
            count_nxt  = count_r + CNT_W'(1);
          end else begin
            count_nxt  = count_r - CNT_W'(1);
          end
          state_nxt = ple_pkg::ST_EMIT;
        end
      end

      ple_pkg::ST_LIST: begin
        load_out = rdv_r && out_free;
        issue    = (left_r != '0) && (!rdv_r || load_out);
        if (load_out) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ple_pkg::STAT_OK;
          out_value_nxt  = rd_data;
          out_last_nxt   = rd_last_r;
        end
        if (issue) begin
          mem_req.re  = 1'b1;
          mem_req.ra  = ptr_r;
          ptr_nxt     = ptr_r + IDX_W'(1);
          left_nxt    = left_r - CNT_W'(1);
          rd_last_nxt = (left_r == CNT_W'(1));
          rdv_nxt     = 1'b1;
        end else if (load_out) begin
          rdv_nxt = 1'b0;
        end
        if ((left_r == '0) && (!rdv_r || load_out)) begin
          state_nxt = ple_pkg::ST_IDLE;
        end
      end

      ple_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ple_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ple_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ple_pkg::ST_IDLE;
      count_r     <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and sequencing registers; the state above qualifies them.
  always_ff @(posedge clk) begin
    left_r       <= left_nxt;
    ptr_r        <= ptr_nxt;
    rd_addr_r    <= rd_addr_nxt;
    rd_last_r    <= rd_last_nxt;
    ins_r        <= ins_nxt;
    first_r      <= first_nxt;
    ins_idx_r    <= ins_idx_nxt;
    ins_val_r    <= ins_val_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_value_r, out_status_r};
  assign out_tlast  = out_last_r;

  // Every accepted item starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ple_pkg::ST_IDLE))
    else $error("accepted item left the sequencer idle");

  // The entry count never passes the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ple_pkg::CAPACITY))
    else $error("entry count above capacity");

  // A shift never reads and writes the same slot in one cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.wa != mem_req.ra))
    else $error("slot read and write collide");

  // The flagged list item is loaded only once no reads are left to issue.
  a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ple_pkg::ST_LIST && load_out && rd_last_r) |-> (left_r == '0))
    else $error("last flag before the list is exhausted");

endmodule

`default_nettype wire

@@ design/ple_slot_store.sv @@
// Slot store of the list: synchronous memory, one read and one write per cycle.
`default_nettype none

module ple_slot_store (
  input  wire logic                    clk,
  input  wire ple_pkg::ple_mem_req_t   req,
  output logic [ple_pkg::VAL_W-1:0]    rd_data
);

  logic [ple_pkg::VAL_W-1:0] mem [ple_pkg::CAPACITY];
  logic [ple_pkg::VAL_W-1:0] rd_data_r;

  // Write the slot.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wa] <= req.wd;
    end
  end

  // Registered read; hold the data while no read is issued.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.ra];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
